/* rtl/pdr_pkg.sv */
// pdr_pkg: shared types and constants for the damped repulsion particle core
// no dependencies
`default_nettype none
package pdr_pkg;
  localparam int unsigned W = 32;
  localparam logic signed [W-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] S32_MIN = 32'sh80000000;
  localparam logic [31:0] DEG_PER_RAD_Q24 = 32'd961263669;

  typedef enum logic [2:0] {
    REG_DAMPING = 3'd0, REG_ROT = 3'd1, REG_SPIN = 3'd2, REG_RADIUS = 3'd3, REG_SCALE = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DEG, OP_DIFF, OP_SQ1, OP_SQ2, OP_SQRT, OP_PCT, OP_TMUL,
    OP_XMUL, OP_XDIV, OP_YMUL, OP_YDIV, OP_DAMP, OP_FORCE, OP_VEL, OP_POS,
    OP_SPD1, OP_SPD2, OP_SPDSQ, OP_GAIN, OP_HMUL, OP_HEAD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic start_unit;
    op_t  unit_op;
  } pdr_cmd_t;

  typedef struct packed {
    logic unit_busy;
    logic in_reach;
    logic len_ok;
  } pdr_stat_t;

  // word layouts on the in / out channels
  typedef struct packed {
    logic               cmd;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] repel_x;
    logic signed [31:0] repel_y;
    logic               repel_on;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_angle;
  } particle_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] heading_deg;
  } particle_out_t;

  function automatic logic signed [W-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return S32_MAX;
    if (v < -66'sd2147483648) return S32_MIN;
    return v[W-1:0];
  endfunction
endpackage
`default_nettype wire

/* rtl/pdr_if.sv */
// pdr_stream_if: valid/ready channel carrying one packed word
// depends on nothing but its payload type parameter
`default_nettype none
interface pdr_stream_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/particle_damped_repulsion_step_core.sv */
// particle_damped_repulsion_step_core: top level of the particle stepper
// uses the in / out channels, a plain cfg write port, control fsm and datapath
// one word in, one word out: a load places the particle, a frame steps it
// cmd 1 loads position and heading (radians to degrees) and clears velocity
// cmd 0 applies force, optional repulsion and damping, then euler-integrates and turns the heading
// acceptance to out_valid takes a different path for a load, a frame
// without repulsion, one with the source out of reach, one on the source
// point and one with full repulsion; its length is set by the shared bit-serial sqrt /
// divide unit (32 steps per root, 64 per quotient)
// one word at a time; in_ready is high only when idle, so a new word is
// taken only after the previous result word has been taken
// the result word is held on the out channel until taken; a stall just waits
// reset clears particle state to zero and loads register defaults
// cfg writes must only happen while the core is idle
`default_nettype none
module particle_damped_repulsion_step_core import pdr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  pdr_stream_if.sink         in_ch,
  pdr_stream_if.source       out_ch,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_idx,
  input  wire logic [31:0]   cfg_data
);
  // input word: cmd, force xy, repel xy, repel_on, start xy, start angle
  logic [15:0] damping_r;
  logic signed [15:0] rot_r, spin_r;
  logic [30:0] radius_r;
  logic signed [31:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r <= 16'd328; rot_r <= '0; spin_r <= '0; radius_r <= '0; scale_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DAMPING: damping_r <= cfg_data[15:0];
        REG_ROT: rot_r <= cfg_data[15:0];
        REG_SPIN: spin_r <= cfg_data[15:0];
        REG_RADIUS: radius_r <= cfg_data[30:0];
        REG_SCALE: scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pdr_cmd_t cmd;
  pdr_stat_t stat;
  logic cap;
  logic signed [31:0] res_px, res_py, res_vx, res_vy, res_hd;
  assign cap = in_ch.valid && in_ch.ready;

  // result word is the particle state after the item
  assign out_ch.data = {res_px, res_py, res_vx, res_vy, res_hd};

  pdr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_cmd(in_ch.data.cmd),
    .rep_en(in_ch.data.repel_on && (radius_r != '0)),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  pdr_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .cap(cap),
    .in_cmd_b(in_ch.data.cmd), .f_x(in_ch.data.force_x), .f_y(in_ch.data.force_y),
    .r_x(in_ch.data.repel_x), .r_y(in_ch.data.repel_y), .s_x(in_ch.data.start_x),
    .s_y(in_ch.data.start_y), .s_a(in_ch.data.start_angle),
    .damping(damping_r), .rot(rot_r), .spin(spin_r), .radius(radius_r), .scale(scale_r),
    .pos_x(res_px), .pos_y(res_py), .vel_x(res_vx), .vel_y(res_vy), .head(res_hd)
  );
endmodule
`default_nettype wire

/* rtl/pdr_ctrl.sv */
// pdr_ctrl: sequencer stepping the datapath through load or frame ops
// depends on pdr_pkg
`default_nettype none
module pdr_ctrl import pdr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_cmd,
  input  wire logic      rep_en,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output pdr_cmd_t       cmd,
  input  wire pdr_stat_t stat
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_OUT} state_t;
  state_t state_r;
  op_t op_r;
  logic start_r, outv_r;

  assign in_ready = (state_r == S_IDLE) && rst_n;
  assign out_valid = outv_r;
  assign cmd = '{op: (state_r == S_RUN) ? op_r : OP_NONE, start_unit: start_r,
                 unit_op: op_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; op_r <= OP_NONE; start_r <= 1'b0; outv_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_RUN;
            op_r <= in_cmd ? OP_LOAD : (rep_en ? OP_DIFF : OP_DAMP);
          end
        end
        S_RUN: begin
          case (op_r)
            OP_LOAD: op_r <= OP_DEG;
            OP_DEG: begin state_r <= S_OUT; outv_r <= 1'b1; end
            OP_DIFF: op_r <= stat.in_reach ? OP_SQ1 : OP_DAMP;
            OP_SQ1: op_r <= OP_SQ2;
            OP_SQ2: begin op_r <= OP_SQRT; start_r <= 1'b1; state_r <= S_WAIT; end
            OP_SQRT: begin
              if (stat.len_ok) begin
                op_r <= OP_PCT; start_r <= 1'b1; state_r <= S_WAIT;
              end else op_r <= OP_DAMP;
            end
            OP_PCT: op_r <= OP_TMUL;
            OP_TMUL: op_r <= OP_XMUL;
            OP_XMUL: begin op_r <= OP_XDIV; start_r <= 1'b1; state_r <= S_WAIT; end
            OP_XDIV: op_r <= OP_YMUL;
            OP_YMUL: begin op_r <= OP_YDIV; start_r <= 1'b1; state_r <= S_WAIT; end
            OP_YDIV: op_r <= OP_DAMP;
            OP_DAMP: op_r <= OP_FORCE;
            OP_FORCE: op_r <= OP_VEL;
            OP_VEL: op_r <= OP_POS;
            OP_POS: op_r <= OP_SPD1;
            OP_SPD1: op_r <= OP_SPD2;
            OP_SPD2: begin op_r <= OP_SPDSQ; start_r <= 1'b1; state_r <= S_WAIT; end
            OP_SPDSQ: op_r <= OP_GAIN;
            OP_GAIN: op_r <= OP_HMUL;
            OP_HMUL: op_r <= OP_HEAD;
            OP_HEAD: begin state_r <= S_OUT; outv_r <= 1'b1; end
            default: begin state_r <= S_OUT; outv_r <= 1'b1; end
          endcase
        end
        S_WAIT: begin
          if (!start_r && !stat.unit_busy) state_r <= S_RUN;
        end
        S_OUT: begin
          if (out_ready) begin state_r <= S_IDLE; outv_r <= 1'b0; end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/pdr_datapath.sv */
// pdr_datapath: particle state, multiplier steps and a shared
// bit-serial square root / divider unit; depends on pdr_pkg
`default_nettype none
module pdr_datapath import pdr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pdr_cmd_t             cmd,
  output pdr_stat_t                 stat,
  input  wire logic                 cap,
  input  wire logic                 in_cmd_b,
  input  wire logic signed [31:0]   f_x, f_y, r_x, r_y, s_x, s_y, s_a,
  input  wire logic [15:0]          damping,
  input  wire logic signed [15:0]   rot, spin,
  input  wire logic [30:0]          radius,
  input  wire logic signed [31:0]   scale,
  output logic signed [31:0]        pos_x, pos_y, vel_x, vel_y, head
);
  logic signed [31:0] px_r, py_r, vx_r, vy_r, hd_r;
  logic signed [31:0] fx_r, fy_r, rx_r, ry_r, sa_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [65:0] fxa_r, fya_r;
  logic signed [65:0] prod_r;
  logic [63:0] sq_r;
  logic [31:0] len_r;
  logic signed [63:0] t_r;
  logic signed [31:0] gain_r;
  logic signed [65:0] dampx_r, dampy_r;

  // shared unit: mode 0 sqrt of 64 bits, mode 1 unsigned 64/32 divide
  logic        u_busy_r, u_mode_r;
  logic [5:0]  u_cnt_r;
  logic [63:0] u_num_r;
  logic [65:0] u_rem_r;
  logic [63:0] u_q_r;
  logic [31:0] u_den_r;
  logic [65:0] trial;
  logic [65:0] rem_sh;

  assign pos_x = px_r; assign pos_y = py_r;
  assign vel_x = vx_r; assign vel_y = vy_r; assign head = hd_r;

  // offset from the source point, valid while the diff step runs
  logic signed [32:0] dx_w, dy_w;
  assign dx_w = 33'(px_r) - 33'(rx_r);
  assign dy_w = 33'(py_r) - 33'(ry_r);

  logic signed [32:0] rad_s;
  assign rad_s = {2'b00, radius};
  assign stat = '{
    unit_busy: u_busy_r,
    in_reach: (dx_w <= rad_s) && (dx_w >= -rad_s) && (dy_w <= rad_s) && (dy_w >= -rad_s),
    len_ok: (u_q_r[31:0] != 32'd0) && (u_q_r[31:0] <= {1'b0, radius})
  };

  always_comb begin
    rem_sh = u_mode_r ? {u_rem_r[64:0], u_num_r[63]}
                      : {u_rem_r[63:0], u_num_r[63:62]};
    trial  = u_mode_r ? {34'd0, u_den_r} : {u_q_r[63:0], 2'b01};
  end

  // magnitude helpers
  logic [32:0] adx, ady, avx, avy;
  assign adx = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign ady = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign avx = vx_r[31] ? 33'(-{vx_r[31], vx_r}) : 33'({vx_r[31], vx_r});
  assign avy = vy_r[31] ? 33'(-{vy_r[31], vy_r}) : 33'({vy_r[31], vy_r});

  logic signed [65:0] neg_q;
  logic signed [65:0] quo;
  logic [31:0] pct;
  logic signed [31:0] t_sh;
  assign pct = u_q_r[31:0];
  assign quo = prod_r[65] ? -$signed({2'b00, u_q_r}) : $signed({2'b00, u_q_r});
  assign neg_q = quo;
  // scaled push strength fits 32 bits since pct stays below one
  assign t_sh = 32'(t_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (cap) begin
      fx_r <= f_x; fy_r <= f_y; rx_r <= r_x; ry_r <= r_y; sa_r <= s_a;
    end
    if (!rst_n) begin
      u_busy_r <= 1'b0;
    end else if (cmd.start_unit) begin
      u_busy_r <= 1'b1;
      u_rem_r <= '0;
      u_q_r <= '0;
      case (cmd.unit_op)
        OP_SQRT, OP_SPDSQ: begin u_mode_r <= 1'b0; u_num_r <= sq_r; u_cnt_r <= 6'd31; end
        OP_PCT: begin
          u_mode_r <= 1'b1; u_cnt_r <= 6'd63; u_den_r <= {1'b0, radius};
          u_num_r <= 64'({1'b0, radius} - len_r) << FRAC_BITS;
        end
        default: begin
          u_mode_r <= 1'b1; u_cnt_r <= 6'd63; u_den_r <= len_r;
          u_num_r <= prod_r[65] ? 64'(-prod_r) : 64'(prod_r);
        end
      endcase
    end else if (u_busy_r) begin
      u_num_r <= u_mode_r ? {u_num_r[62:0], 1'b0} : {u_num_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        u_rem_r <= rem_sh - trial;
        u_q_r <= {u_q_r[62:0], 1'b1};
      end else begin
        u_rem_r <= rem_sh;
        u_q_r <= {u_q_r[62:0], 1'b0};
      end
      if (u_cnt_r == 6'd0) u_busy_r <= 1'b0;
      u_cnt_r <= u_cnt_r - 6'd1;
    end
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; vx_r <= '0; vy_r <= '0; hd_r <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          vx_r <= '0; vy_r <= '0;
          prod_r <= 66'(sa_r * $signed({1'b0, DEG_PER_RAD_Q24}));
        end
        OP_DEG: hd_r <= sat32(prod_r >>> 24);
        OP_DIFF: begin
          dx_r <= dx_w; dy_r <= dy_w;
          fxa_r <= 66'(fx_r); fya_r <= 66'(fy_r);
        end
        OP_SQ1: sq_r <= 64'(adx * adx);
        OP_SQ2: sq_r <= sq_r + 64'(ady * ady);
        OP_SQRT: len_r <= u_q_r[31:0];
        OP_TMUL: t_r <= 64'(scale * $signed({1'b0, pct}));
        OP_XMUL: prod_r <= 66'(dx_r * t_sh);
        OP_XDIV: fxa_r <= fxa_r + neg_q;
        OP_YMUL: prod_r <= 66'(dy_r * t_sh);
        OP_YDIV: fya_r <= fya_r + neg_q;
        OP_DAMP: begin
          dampx_r <= 66'(vx_r * $signed({1'b0, damping})) >>> 16;
          dampy_r <= 66'(vy_r * $signed({1'b0, damping})) >>> 16;
        end
        OP_FORCE: begin fxa_r <= fxa_r - dampx_r; fya_r <= fya_r - dampy_r; end
        OP_VEL: begin
          vx_r <= sat32(66'(vx_r) + 66'(sat32(fxa_r)));
          vy_r <= sat32(66'(vy_r) + 66'(sat32(fya_r)));
        end
        OP_POS: begin
          px_r <= sat32(66'(px_r) + 66'(vx_r));
          py_r <= sat32(66'(py_r) + 66'(vy_r));
        end
        OP_SPD1: sq_r <= 64'(avx * avx);
        OP_SPD2: sq_r <= sq_r + 64'(avy * avy);
        OP_SPDSQ: begin len_r <= u_q_r[31:0]; gain_r <= 32'(rot * spin); end
        OP_GAIN: t_r <= 64'($signed({1'b0, len_r}) * gain_r);
        OP_HMUL: prod_r <= 66'(t_r) >>> 23;
        OP_HEAD: hd_r <= sat32(66'(hd_r) + prod_r);
        default: ;
      endcase
      if (cap && in_cmd_b) begin px_r <= s_x; py_r <= s_y; end
      if (cap && !in_cmd_b) begin fxa_r <= 66'(f_x); fya_r <= 66'(f_y); end
    end
  end
endmodule
`default_nettype wire
